@@ rtl/hlc_pkg.sv @@
// Package for the homogeneous line clip and project block: types, constants, helpers.
package hlc_pkg;

  localparam int unsigned CfgAw = 6;
  localparam int unsigned CoordW = 40;

  localparam logic [CfgAw-1:0] AddrRow0 = 6'h00;
  localparam logic [CfgAw-1:0] AddrRow1 = 6'h08;
  localparam logic [CfgAw-1:0] AddrRow2 = 6'h10;
  localparam logic [CfgAw-1:0] AddrRow3 = 6'h18;
  localparam logic [CfgAw-1:0] AddrMode = 6'h20;

  localparam logic [63:0] Row0Rst = 64'h0000_0000_0000_1000;
  localparam logic [63:0] Row1Rst = 64'h0000_0000_1000_0000;
  localparam logic [63:0] Row2Rst = 64'h0000_1000_0000_0000;
  localparam logic [63:0] Row3Rst = 64'h1000_0000_0000_0000;

  localparam logic signed [23:0] XyMax = 24'sh7FFFFF;
  localparam logic signed [23:0] XyMin = -24'sh800000;
  localparam logic signed [23:0] ZMax = 24'sd16384;
  localparam logic signed [23:0] ZMin = -24'sd16384;

  localparam logic [16:0] FracOne = 17'h10000;

  typedef logic signed [CoordW-1:0] coord_t;

  // Divider request and response.
  typedef struct packed {
    logic         start;
    logic [63:0]  num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [63:0]  quo;
  } div_rsp_t;

endpackage

@@ rtl/hlc_div.sv @@
// Shared radix-2 restoring divider for unsigned 64-bit operands.
module hlc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hlc_pkg::div_req_t    req_i,
  output hlc_pkg::div_rsp_t    rsp_o
);
  import hlc_pkg::*;

  logic [63:0]  quo_q, quo_d;
  logic [64:0]  rem_q, rem_d;
  logic [63:0]  den_q, den_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [64:0]  trial;
  logic [64:0]  shifted;

  always_comb begin
    shifted = {rem_q[63:0], quo_q[63]};
    trial   = shifted - {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ rtl/hlc_core.sv @@
// Sequencer with a shared multiply-accumulate unit: transform, pairing, clip, divide.
module hlc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [63:0]           row_i [4],
  input  logic                  mode_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic signed [15:0]    pos_z_i,
  input  logic                  first_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [143:0]          out_data_o,
  output hlc_pkg::div_req_t     div_req_o,
  input  hlc_pkg::div_rsp_t     div_rsp_i
);
  import hlc_pkg::*;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StMac   = 11'b00000000010,
    StPair  = 11'b00000000100,
    StBound = 11'b00000001000,
    StFrac  = 11'b00000010000,
    StFracW = 11'b00000100000,
    StLerp1 = 11'b00001000000,
    StLerp2 = 11'b00010000000,
    StDiv   = 11'b00100000000,
    StDivW  = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [15:0] px_q, py_q, pz_q;
  logic first_q;
  logic [1:0] row_q;
  logic [1:0] col_q;
  logic signed [CoordW-1:0] acc_q;
  coord_t cur_q [4];
  coord_t s1_q [4];
  coord_t s2_q [4];
  logic signed [31:0] last_q [4];
  logic phase_q, have_q;
  logic signed [CoordW-1:0] bn1_q, bn2_q, bf1_q, bf2_q;
  logic [16:0] a1_q, a2_q;
  logic fsel_q;
  logic fnear_q;
  logic [2:0] didx_q;
  logic dneg_q;
  logic signed [23:0] res_q [6];
  logic [143:0] out_q;
  logic ovalid_q;

  // shared multiplier operands
  logic signed [15:0] mac_a;
  logic signed [16:0] mac_b;
  logic signed [32:0] mac_p;

  function automatic logic signed [16:0] pos_x_sgn(input logic signed [15:0] v);
    pos_x_sgn = {v[15], v};
  endfunction

  always_comb begin
    mac_a = row_i[row_q][16*col_q +: 16];
    case (col_q)
      2'd0:    mac_b = {pos_x_sgn(px_q)};
      2'd1:    mac_b = {pos_x_sgn(py_q)};
      2'd2:    mac_b = {pos_x_sgn(pz_q)};
      default: mac_b = 17'sd256;
    endcase
    mac_p = 33'(mac_a * mac_b);
  end

  // lerp: s + floor(((t - s) * a + 32768) / 65536), one lane per cycle
  logic [1:0] lane_q;
  logic signed [CoordW:0] ldiff;
  logic signed [CoordW+18:0] lprod;
  logic signed [CoordW-1:0] lres;
  logic [16:0] lfrac;
  coord_t ls, lt;

  always_comb begin
    ls    = (state_q == StLerp1) ? s1_q[lane_q] : s2_q[lane_q];
    lt    = (state_q == StLerp1) ? s2_q[lane_q] : s1_q[lane_q];
    lfrac = (state_q == StLerp1) ? a1_q : FracOne - a2_q;
    ldiff = (CoordW+1)'(lt) - (CoordW+1)'(ls);
    lprod = (CoordW+19)'(ldiff * $signed({1'b0, lfrac})) + (CoordW+19)'(32768);
    lres  = ls + CoordW'(lprod >>> 16);
  end

  // fraction numerator/denominator
  logic signed [CoordW-1:0] fb1, fb2;
  logic signed [CoordW:0] fd;
  logic [CoordW:0] fmagn, fmagd;
  always_comb begin
    fb1   = fnear_q ? bn1_q : bf1_q;
    fb2   = fnear_q ? bn2_q : bf2_q;
    fd    = (CoordW+1)'(fb1) - (CoordW+1)'(fb2);
    fmagn = fb1[CoordW-1] ? (CoordW+1)'(-(CoordW+1)'(fb1)) : (CoordW+1)'(fb1);
    fmagd = fd[CoordW] ? (CoordW+1)'(-fd) : (CoordW+1)'(fd);
  end

  // divide operands for output index
  coord_t dc, dw;
  logic signed [CoordW+14:0] dn;
  logic [CoordW+14:0] dmn;
  logic [CoordW-1:0] dmw;
  logic signed [23:0] dhi, dlo;
  logic [63:0] dq;
  logic [63:0] dmax;
  logic signed [23:0] dres;
  always_comb begin
    dc   = (didx_q < 3'd3) ? s1_q[didx_q[1:0]] : s2_q[2'(didx_q - 3'd3)];
    dw   = (didx_q < 3'd3) ? s1_q[3] : s2_q[3];
    dn   = (CoordW+15)'(dc) <<< 14;
    dmn  = dn[CoordW+14] ? (CoordW+15)'(-dn) : (CoordW+15)'(dn);
    dmw  = dw[CoordW-1] ? CoordW'(-dw) : CoordW'(dw);
    dhi  = (didx_q == 3'd2 || didx_q == 3'd5) ? ZMax : XyMax;
    dlo  = (didx_q == 3'd2 || didx_q == 3'd5) ? ZMin : XyMin;
    dq   = div_rsp_i.quo;
    dmax = dneg_q ? 64'(-(64'(dlo))) : 64'(dhi);
    if (dq >= dmax) begin
      dres = dneg_q ? dlo : dhi;
    end else begin
      dres = dneg_q ? 24'(-$signed({1'b0, dq[23:0]})) : dq[23:0];
    end
  end

  logic emit;
  logic signed [23:0] dzc, dzp, dzm;

  always_comb begin
    emit = !first_q && have_q && (!mode_i || phase_q);
  end

  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = '0;
    div_req_o.den   = '0;
    if (state_q == StFrac && !fsel_q) begin
      div_req_o.start = 1'b1;
      div_req_o.num   = 64'(fmagn) << 16;
      div_req_o.den   = 64'(fmagd);
    end else if (state_q == StDiv && dw != '0) begin
      div_req_o.start = 1'b1;
      div_req_o.num   = 64'(dmn) << 1;
      div_req_o.num   = div_req_o.num + 64'(dmw);
      div_req_o.den   = 64'(dmw) << 1;
    end
  end

  always_comb begin
    dzc = res_q[2];
    dzp = res_q[5];
    dzm = (dzc > dzp) ? dzc : dzp;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      phase_q  <= 1'b0;
      have_q   <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 4; i++) last_q[i] <= '0;
    end else begin
      if (ovalid_q && out_ready_i && state_q != StOut) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            px_q    <= pos_x_i;
            py_q    <= pos_y_i;
            pz_q    <= pos_z_i;
            first_q <= first_i;
            row_q   <= '0;
            col_q   <= '0;
            acc_q   <= '0;
            state_q <= StMac;
          end
        end
        StMac: begin
          if (col_q == 2'd3) begin
            cur_q[row_q] <= CoordW'((acc_q + CoordW'(mac_p) + CoordW'(128)) >>> 8);
            acc_q <= '0;
            col_q <= '0;
            row_q <= row_q + 2'd1;
            if (row_q == 2'd3) state_q <= StPair;
          end else begin
            acc_q <= acc_q + CoordW'(mac_p);
            col_q <= col_q + 2'd1;
          end
        end
        StPair: begin
          if (first_q || !have_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= !phase_q;
          end
          have_q <= 1'b1;
          for (int i = 0; i < 4; i++) begin
            s2_q[i]   <= CoordW'(last_q[i]);
            s1_q[i]   <= cur_q[i];
            last_q[i] <= 32'(cur_q[i]);
          end
          a1_q  <= '0;
          a2_q  <= FracOne;
          state_q <= emit ? StBound : StIdle;
        end
        StBound: begin
          bn1_q <= s1_q[2] + s1_q[3];
          bn2_q <= s2_q[2] + s2_q[3];
          bf1_q <= s1_q[3] - s1_q[2];
          bf2_q <= s2_q[3] - s2_q[2];
          fnear_q <= 1'b1;
          fsel_q  <= 1'b1;
          state_q <= StFrac;
        end
        StFrac: begin
          if (fsel_q) begin
            fsel_q <= 1'b0;
            if (!(bn1_q >= 0 && bn2_q >= 0 && bf1_q >= 0 && bf2_q >= 0)) begin
              if ((bn1_q < 0 && bn2_q < 0) || (bf1_q < 0 && bf2_q < 0)) begin
                state_q <= StIdle;
              end else if (bn1_q < 0 || bn2_q < 0) begin
                fnear_q <= 1'b1;
                state_q <= StFrac;
              end else begin
                fnear_q <= 1'b0;
                state_q <= StFrac;
              end
            end else begin
              didx_q  <= '0;
              state_q <= StDiv;
            end
          end else begin
            state_q <= StFracW;
          end
        end
        StFracW: begin
          if (div_rsp_i.done) begin
            if (fnear_q) begin
              if (bn1_q < 0) begin
                if (div_rsp_i.quo[16:0] > a1_q) a1_q <= div_rsp_i.quo[16:0];
              end else begin
                if (div_rsp_i.quo[16:0] < a2_q) a2_q <= div_rsp_i.quo[16:0];
              end
            end else begin
              if (bf1_q < 0) begin
                if (div_rsp_i.quo[16:0] > a1_q) a1_q <= div_rsp_i.quo[16:0];
              end else begin
                if (div_rsp_i.quo[16:0] < a2_q) a2_q <= div_rsp_i.quo[16:0];
              end
            end
            if (fnear_q && (bf1_q < 0 || bf2_q < 0)) begin
              fnear_q <= 1'b0;
              state_q <= StFrac;
            end else begin
              lane_q  <= '0;
              state_q <= StLerp1;
            end
          end
        end
        StLerp1: begin
          if (lane_q == 2'd0 && a2_q < a1_q) begin
            state_q <= StIdle;
          end else begin
            s1_q[lane_q] <= lres;
            lane_q <= lane_q + 2'd1;
            if (lane_q == 2'd3) state_q <= StLerp2;
          end
        end
        StLerp2: begin
          s2_q[lane_q] <= lres;
          lane_q <= lane_q + 2'd1;
          if (lane_q == 2'd3) begin
            didx_q  <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          dneg_q  <= dn[CoordW+14] != dw[CoordW-1];
          if (dw == '0) begin
            res_q[didx_q] <= (dn > 0) ? dhi : ((dn < 0) ? dlo : '0);
            if (didx_q == 3'd5) state_q <= StOut;
            didx_q <= didx_q + 3'd1;
          end else begin
            state_q <= StDivW;
          end
        end
        StDivW: begin
          if (div_rsp_i.done) begin
            res_q[didx_q] <= dres;
            didx_q <= didx_q + 3'd1;
            state_q <= (didx_q == 3'd5) ? StOut : StDiv;
          end
        end
        StOut: begin
          if (!ovalid_q || out_ready_i) begin
            out_q <= {dzm[15:0], res_q[5][15:0], res_q[4], res_q[3],
                      res_q[2][15:0], res_q[1], res_q[0]};
            ovalid_q <= 1'b1;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ rtl/homogeneous_line_clip_project.sv @@
// Top level: APB register file, streaming ports, sequencer and shared divider.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: pos_x, pos_y, pos_z, tuser: first_vertex
//  m_axis   | out       | tdata: cur_x, cur_y, cur_z, prev_x, prev_y, prev_z, seg_depth
//  apb      | in        | mvp_row0..3 at 0x00..0x18, line_mode at 0x20
//
// The transform runs on one multiplier and each divide on the shared radix-2 divider;
// a clipped segment uses up to two fraction and six output divides.
// Reset clears matrix to identity, line state and the output valid flag.
// A held result blocks the next one only at hand-over; the next vertex is accepted meanwhile.
module homogeneous_line_clip_project (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [47:0]   s_axis_tdata_i,  // pos_x, pos_y, pos_z
  input  logic          s_axis_tuser_i,  // first_vertex
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [143:0]  m_axis_tdata_o,  // cur_x, cur_y, cur_z, prev_x, prev_y, prev_z, seg_depth
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import hlc_pkg::*;

  logic [63:0] row_q [4];
  logic mode_q;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= Row0Rst;
      row_q[1] <= Row1Rst;
      row_q[2] <= Row2Rst;
      row_q[3] <= Row3Rst;
      mode_q   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrRow0: row_q[0] <= pwdata;
        AddrRow1: row_q[1] <= pwdata;
        AddrRow2: row_q[2] <= pwdata;
        AddrRow3: row_q[3] <= pwdata;
        AddrMode: mode_q   <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrRow0: prdata = row_q[0];
      AddrRow1: prdata = row_q[1];
      AddrRow2: prdata = row_q[2];
      AddrRow3: prdata = row_q[3];
      AddrMode: prdata = {63'd0, mode_q};
      default:  prdata = '0;
    endcase
  end

  hlc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_i       (row_q),
    .mode_i      (mode_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .pos_x_i     (s_axis_tdata_i[15:0]),
    .pos_y_i     (s_axis_tdata_i[31:16]),
    .pos_z_i     (s_axis_tdata_i[47:32]),
    .first_i     (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  hlc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

@@ rtl/hlc_checker.sv @@
// Port-level checker for the line clip block, bound to the top level.
module hlc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tvalid_i,
  input logic          s_axis_tready_o,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [143:0]  m_axis_tdata_o,
  input logic          pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[143:128]) >= $signed(m_axis_tdata_o[63:48]))
      && ($signed(m_axis_tdata_o[143:128]) >= $signed(m_axis_tdata_o[127:112])))
    else $error("depth key below an end z");
  a_ready: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind homogeneous_line_clip_project hlc_checker u_chk (.*);
